@@ design/acm_pkg.sv @@
// Package for the averaging channel mixer.
// Holds slot constants, the controller state type and the command/status structs.
// No dependencies; compile first.
package acm_pkg;

    // Slot configuration
    localparam int NUM_SLOTS = 4;
    localparam int MAX_SLOTS = 4;

    // Field widths fixed by the item format
    localparam int LEN_W    = 32;
    localparam int SMP_W    = 8;
    localparam int SLOT_W   = 2;
    localparam int MASK_W   = MAX_SLOTS;

    // Internal widths derived from the slot count
    localparam int CNT_W    = $clog2(NUM_SLOTS + 1);
    localparam int SUM_W    = SMP_W + $clog2(NUM_SLOTS);

    // Divide-by-three reciprocal: floor(x * 683 / 2048) == floor(x / 3) for x <= 1023
    localparam int RECIP3_W     = 10;
    localparam int RECIP3_SHIFT = 11;
    localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;

    // Codes
    localparam logic       REQ_PLAY       = 1'b0;
    localparam logic       REQ_TICK       = 1'b1;
    localparam logic [7:0] DIRECT_OUT_CMD = 8'h10;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_PLAY_RSP,
        S_CMD_RSP,
        S_SMP_RSP
    } acm_state_t;

    // Which result the output payload carries
    typedef enum logic [1:0] {
        OSEL_PLAY,
        OSEL_CMD,
        OSEL_SAMPLE
    } acm_osel_t;

    typedef struct packed {
        logic      load;     // take the input item and update slot state
        logic      divide;   // register the averaged sample
        acm_osel_t out_sel;  // result shown on the output
    } acm_cmd_t;

    typedef struct packed {
        logic req_is_play;   // request type of the item at the input
        logic any_active;    // last accepted item saw at least one active slot
    } acm_status_t;

endpackage

@@ design/acm_if.sv @@
// Handshake interfaces for the mixer's request and result channels.
// Valid/ready with payload; no dependencies.
interface acm_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] play_length;
    logic [7:0]  sample_0;
    logic [7:0]  sample_1;
    logic [7:0]  sample_2;
    logic [7:0]  sample_3;

    modport source (
        output valid, req_type, play_length, sample_0, sample_1, sample_2, sample_3,
        input  ready
    );
    modport sink (
        input  valid, req_type, play_length, sample_0, sample_1, sample_2, sample_3,
        output ready
    );
endinterface

interface acm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] dsp_byte;
    logic       last;
    logic       play_accepted;
    logic [1:0] play_slot;
    logic [3:0] consumed_mask;

    modport source (
        output valid, dsp_byte, last, play_accepted, play_slot, consumed_mask,
        input  ready
    );
    modport sink (
        input  valid, dsp_byte, last, play_accepted, play_slot, consumed_mask,
        output ready
    );
endinterface

@@ design/acm_datapath.sv @@
// Datapath of the mixer: slot length/position registers, tick sum and average.
// Depends on acm_pkg; driven by acm_ctrl through acm_cmd_t.
module acm_datapath
    import acm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  acm_cmd_t          cmd,
    output acm_status_t       status,
    input  logic              req_type,
    input  logic [LEN_W-1:0]  play_length,
    input  logic [SMP_W-1:0]  sample_0,
    input  logic [SMP_W-1:0]  sample_1,
    input  logic [SMP_W-1:0]  sample_2,
    input  logic [SMP_W-1:0]  sample_3,
    output logic [7:0]        dsp_byte,
    output logic              last,
    output logic              play_accepted,
    output logic [SLOT_W-1:0] play_slot,
    output logic [MASK_W-1:0] consumed_mask
);

    logic [LEN_W-1:0]  len_reg [NUM_SLOTS];
    logic [LEN_W-1:0]  pos_reg [NUM_SLOTS];
    logic [SMP_W-1:0]  samples [MAX_SLOTS];

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [NUM_SLOTS-1:0] act;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  cnt_next;

    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              acc_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SMP_W-1:0]  avg_reg;

    logic [SUM_W+RECIP3_W-1:0] prod3;
    logic [SMP_W-1:0]          avg_next;

    assign samples[0] = sample_0;
    assign samples[1] = sample_1;
    assign samples[2] = sample_2;
    assign samples[3] = sample_3;

    // Find the lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!free_found && (len_reg[i] == '0))
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Active slots, sample sum and active count for a tick
    always_comb
    begin
        sum_next = '0;
        cnt_next = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            act[i] = pos_reg[i] < len_reg[i];
            if (act[i])
            begin
                sum_next = sum_next + SUM_W'(samples[i]);
                cnt_next = cnt_next + CNT_W'(1);
            end
        end
    end

    // Update slot state on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                len_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            if (req_type == REQ_PLAY)
            begin
                if (free_found)
                begin
                    len_reg[free_idx] <= play_length;
                    pos_reg[free_idx] <= '0;
                end
            end
            else
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (act[i])
                        pos_reg[i] <= pos_reg[i] + LEN_W'(1);
                    else
                        len_reg[i] <= '0;
                end
            end
        end
    end

    // Capture the item's result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            mask_reg <= MASK_W'(act);
            acc_reg  <= free_found;
            slot_reg <= free_found ? free_idx : '0;
        end
    end

    // Average: shifts for one, two and four slots, reciprocal for three
    assign prod3 = SUM_W'(sum_reg) * RECIP3;

    always_comb
    begin
        unique case (cnt_reg)
            CNT_W'(1): avg_next = SMP_W'(sum_reg);
            CNT_W'(2): avg_next = SMP_W'(sum_reg >> 1);
            CNT_W'(3): avg_next = SMP_W'(prod3 >> RECIP3_SHIFT);
            CNT_W'(4): avg_next = SMP_W'(sum_reg >> 2);
            default:   avg_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.divide)
            avg_reg <= avg_next;
    end

    assign status.req_is_play = (req_type == REQ_PLAY);
    assign status.any_active  = (cnt_reg != '0);

    // Drive the result payload
    always_comb
    begin
        unique case (cmd.out_sel)
            OSEL_PLAY:
            begin
                dsp_byte      = '0;
                last          = 1'b1;
                play_accepted = acc_reg;
                play_slot     = slot_reg;
                consumed_mask = '0;
            end
            OSEL_CMD:
            begin
                dsp_byte      = DIRECT_OUT_CMD;
                last          = 1'b0;
                play_accepted = 1'b0;
                play_slot     = '0;
                consumed_mask = mask_reg;
            end
            OSEL_SAMPLE:
            begin
                dsp_byte      = avg_reg;
                last          = 1'b1;
                play_accepted = 1'b0;
                play_slot     = '0;
                consumed_mask = mask_reg;
            end
            default:
            begin
                dsp_byte      = '0;
                last          = 1'b0;
                play_accepted = 1'b0;
                play_slot     = '0;
                consumed_mask = '0;
            end
        endcase
    end

endmodule

@@ design/acm_ctrl.sv @@
// Controller of the mixer: sequences load, average and result delivery.
// Depends on acm_pkg; commands acm_datapath.
module acm_ctrl
    import acm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  acm_status_t status,
    output acm_cmd_t    cmd
);

    acm_state_t state_reg;
    acm_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = status.req_is_play ? S_PLAY_RSP : S_DIVIDE;
            end
            S_DIVIDE:
            begin
                state_next = status.any_active ? S_CMD_RSP : S_IDLE;
            end
            S_PLAY_RSP:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            S_CMD_RSP:
            begin
                if (out_ready)
                    state_next = S_SMP_RSP;
            end
            S_SMP_RSP:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.load    = 1'b0;
        cmd.divide  = 1'b0;
        cmd.out_sel = OSEL_PLAY;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DIVIDE:
            begin
                cmd.divide = 1'b1;
            end
            S_PLAY_RSP:
            begin
                out_valid   = 1'b1;
                cmd.out_sel = OSEL_PLAY;
            end
            S_CMD_RSP:
            begin
                out_valid   = 1'b1;
                cmd.out_sel = OSEL_CMD;
            end
            S_SMP_RSP:
            begin
                out_valid   = 1'b1;
                cmd.out_sel = OSEL_SAMPLE;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ design/averaging_channel_mixer.sv @@
// Top level of the averaging channel mixer.
// Depends on acm_pkg, acm_if, acm_ctrl and acm_datapath.
//
//  Channel | Direction | Payload
//  --------+-----------+------------------------------------------------------
//  req     | in        | req_type, play_length, sample_0..sample_3
//  rsp     | out       | dsp_byte, last, play_accepted, play_slot, consumed_mask
//
// One item at a time. A play request is accepted in the idle state and then
// shows its result; a tick is accepted, passes the averaging state, then gives two
// results (none if no slot is active).
// Reset frees every slot at once. A stalled result holds the controller in
// its result state; no new item is taken until all results are delivered.
module averaging_channel_mixer
    import acm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    acm_req_if.sink   req,
    acm_rsp_if.source rsp
);

    acm_cmd_t    cmd;
    acm_status_t status;

    acm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    acm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req.req_type),
        .play_length   (req.play_length),
        .sample_0      (req.sample_0),
        .sample_1      (req.sample_1),
        .sample_2      (req.sample_2),
        .sample_3      (req.sample_3),
        .dsp_byte      (rsp.dsp_byte),
        .last          (rsp.last),
        .play_accepted (rsp.play_accepted),
        .play_slot     (rsp.play_slot),
        .consumed_mask (rsp.consumed_mask)
    );

endmodule

@@ dv/averaging_channel_mixer_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for averaging_channel_mixer: a directed table, random play requests
// and mixer ticks, checked result by result against an in-bench slot model.
// Depends on acm_pkg, the acm_req_if / acm_rsp_if interfaces and the mixer RTL.
module averaging_channel_mixer_test;
    import acm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 20;

    // One item on the request channel; samples[i] feeds slot i
    typedef struct packed {
        logic                            req_type;
        logic [LEN_W-1:0]                play_length;
        logic [MAX_SLOTS-1:0][SMP_W-1:0] samples;
    } mix_item_t;

    // One item on the result channel
    typedef struct packed {
        logic [SMP_W-1:0]  dsp_byte;
        logic              last;
        logic              play_accepted;
        logic [SLOT_W-1:0] play_slot;
        logic [MASK_W-1:0] consumed_mask;
    } dsp_result_t;

    // Stimulus row; typed rows carry their expected result (or none) inline
    typedef struct packed {
        mix_item_t   item;
        logic        typed;
        logic        has_result;
        dsp_result_t result;
    } stim_row_t;

    logic clk;
    logic rst_n;

    acm_req_if req_ch ();
    acm_rsp_if rsp_ch ();

    averaging_channel_mixer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Slot model state
    logic [LEN_W-1:0] slot_len [MAX_SLOTS];
    logic [LEN_W-1:0] slot_pos [MAX_SLOTS];

    dsp_result_t expected_dsp [$];

    int err_count     = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Apply one item to the slot model; return the number of results it causes
    function automatic int mix_step(input mix_item_t it, output dsp_result_t res [2]);
        logic [31:0]       sum;
        logic [31:0]       active;
        logic [MASK_W-1:0] mask;
        res[0] = '0;
        res[1] = '0;
        sum    = '0;
        active = '0;
        mask   = '0;
        if (it.req_type == REQ_PLAY)
        begin
            // claim the lowest free slot, or refuse
            res[0].last = 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_len[i] == '0)
                begin
                    slot_len[i]          = it.play_length;
                    slot_pos[i]          = '0;
                    res[0].play_accepted = 1'b1;
                    res[0].play_slot     = SLOT_W'(i);
                    return 1;
                end
            end
            return 1;
        end
        // tick: advance active slots, free exhausted ones
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_pos[i] < slot_len[i])
            begin
                sum         = sum + 32'(it.samples[i]);
                slot_pos[i] = slot_pos[i] + 1;
                active      = active + 1;
                mask[i]     = 1'b1;
            end
            else
            begin
                slot_len[i] = '0;
            end
        end
        if (active == '0)
            return 0;
        res[0].dsp_byte      = DIRECT_OUT_CMD;
        res[0].consumed_mask = mask;
        res[1].dsp_byte      = SMP_W'(sum / active);
        res[1].last          = 1'b1;
        res[1].consumed_mask = mask;
        return 2;
    endfunction

    // Row checked against the slot model
    function automatic stim_row_t free_row(input logic req_type, input logic [LEN_W-1:0] len,
                                           input logic [MAX_SLOTS*SMP_W-1:0] smp);
        stim_row_t row;
        row                  = '0;
        row.item.req_type    = req_type;
        row.item.play_length = len;
        row.item.samples     = smp;
        return row;
    endfunction

    // Row with its result typed in: one play result, or nothing for an idle tick
    function automatic stim_row_t typed_row(input logic req_type, input logic [LEN_W-1:0] len,
                                            input logic [MAX_SLOTS*SMP_W-1:0] smp,
                                            input logic has_result, input logic acc,
                                            input logic [SLOT_W-1:0] slot);
        stim_row_t row;
        row                      = free_row(req_type, len, smp);
        row.typed                = 1'b1;
        row.has_result           = has_result;
        row.result.last          = 1'b1;
        row.result.play_accepted = acc;
        row.result.play_slot     = slot;
        return row;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Drive one item, wait for its acceptance, then queue what it should cause
    task automatic send_item(input stim_row_t row);
        dsp_result_t res [2];
        int          n;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= row.item.req_type;
        req_ch.play_length <= row.item.play_length;
        req_ch.sample_0    <= row.item.samples[0];
        req_ch.sample_1    <= row.item.samples[1];
        req_ch.sample_2    <= row.item.samples[2];
        req_ch.sample_3    <= row.item.samples[3];
        do
            @(posedge clk);
        while (!req_ch.ready);
        n = mix_step(row.item, res);
        if (row.typed)
        begin
            if (row.has_result)
                expected_dsp.push_back(row.result);
        end
        else
        begin
            for (int k = 0; k < n; k++)
                expected_dsp.push_back(res[k]);
        end
    endtask

    // Result side back-pressure
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        dsp_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_dsp.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result dsp_byte=%0h last=%0b",
                                          rsp_ch.dsp_byte, rsp_ch.last));
            end
            else
            begin
                want = expected_dsp.pop_front();
                if (rsp_ch.dsp_byte !== want.dsp_byte)
                    report_mismatch($sformatf("dsp_byte %0h, expected %0h",
                                              rsp_ch.dsp_byte, want.dsp_byte));
                if (rsp_ch.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              rsp_ch.last, want.last));
                if (rsp_ch.play_accepted !== want.play_accepted)
                    report_mismatch($sformatf("play_accepted %0b, expected %0b",
                                              rsp_ch.play_accepted, want.play_accepted));
                if (rsp_ch.play_slot !== want.play_slot)
                    report_mismatch($sformatf("play_slot %0d, expected %0d",
                                              rsp_ch.play_slot, want.play_slot));
                if (rsp_ch.consumed_mask !== want.consumed_mask)
                    report_mismatch($sformatf("consumed_mask %0h, expected %0h",
                                              rsp_ch.consumed_mask, want.consumed_mask));
            end
        end
    end

    // Hang guard
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("averaging_channel_mixer_test: FAIL");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        stim_row_t        rows [$];
        stim_row_t        row;
        logic [LEN_W-1:0] len;
        logic             busy;

        foreach (slot_len[i])
        begin
            slot_len[i] = '0;
            slot_pos[i] = '0;
        end
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_TICK;
        req_ch.play_length <= '0;
        req_ch.sample_0    <= '0;
        req_ch.sample_1    <= '0;
        req_ch.sample_2    <= '0;
        req_ch.sample_3    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; samples are packed {slot3, slot2, slot1, slot0}
        // idle tick straight after reset
        rows.push_back(typed_row(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 2'd0));
        // zero-length plays take slot 0 and leave it free
        rows.push_back(typed_row(REQ_PLAY, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'd0));
        rows.push_back(typed_row(REQ_PLAY, 32'd0, 32'h0000_0000, 1'b1, 1'b1, 2'd0));
        // fill all slots, then get refused
        rows.push_back(typed_row(REQ_PLAY, 32'd1, 32'h0000_0000, 1'b1, 1'b1, 2'd0));
        rows.push_back(typed_row(REQ_PLAY, 32'd2, 32'h0000_0000, 1'b1, 1'b1, 2'd1));
        rows.push_back(typed_row(REQ_PLAY, 32'd3, 32'h0000_0000, 1'b1, 1'b1, 2'd2));
        rows.push_back(typed_row(REQ_PLAY, 32'd2, 32'h0000_0000, 1'b1, 1'b1, 2'd3));
        rows.push_back(typed_row(REQ_PLAY, 32'd5, 32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0));
        // four active at full scale, three active (divide by three), one active at zero
        rows.push_back(free_row(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        rows.push_back(free_row(REQ_TICK, 32'h0000_0000, 32'hFEFF_FF00));
        rows.push_back(free_row(REQ_TICK, 32'h0000_0000, 32'h0000_0000));
        // two active with an odd sum: truncation
        rows.push_back(typed_row(REQ_PLAY, 32'd1, 32'h0000_0000, 1'b1, 1'b1, 2'd0));
        rows.push_back(typed_row(REQ_PLAY, 32'd2, 32'h0000_0000, 1'b1, 1'b1, 2'd1));
        rows.push_back(free_row(REQ_TICK, 32'h0000_0000, 32'h3344_C9C8));
        rows.push_back(free_row(REQ_TICK, 32'h0000_0000, 32'hA5A5_A5A5));
        // last sample gone: this tick only frees the slot
        rows.push_back(typed_row(REQ_TICK, 32'h0000_0000, 32'h5A5A_5A5A, 1'b0, 1'b0, 2'd0));
        rows.push_back(typed_row(REQ_PLAY, 32'd7, 32'h0000_0000, 1'b1, 1'b1, 2'd0));
        foreach (rows[r])
            send_item(rows[r]);

        // Random traffic in four idling phases
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 59;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 59;
                end
                default:
                begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                end
            endcase
            for (int k = 0; k < RANDOM_ITEMS / 4; k++)
            begin
                if ($urandom_range(0, 99) < 35)
                begin
                    // short sounds so slots free up and get reclaimed
                    case ($urandom_range(0, 9))
                        0:       len = '0;
                        1:       len = $urandom_range(11, 40);
                        default: len = $urandom_range(1, 10);
                    endcase
                    row = free_row(REQ_PLAY, len, $urandom);
                end
                else
                begin
                    row = free_row(REQ_TICK, $urandom, $urandom);
                end
                send_item(row);
            end
        end

        // Drain every slot, then claim them with long sounds that never run out
        do
        begin
            busy = 1'b0;
            foreach (slot_len[i])
                if (slot_len[i] != '0)
                    busy = 1'b1;
            if (busy)
                send_item(free_row(REQ_TICK, $urandom, $urandom));
        end
        while (busy);
        send_item(free_row(REQ_PLAY, 32'hFFFF_FFFF, $urandom));
        repeat (4) send_item(free_row(REQ_PLAY, $urandom, $urandom));
        repeat (12) send_item(free_row(REQ_TICK, $urandom, $urandom));
        send_item(free_row(REQ_PLAY, $urandom, $urandom));

        // Wait out the remaining results
        req_ch.valid <= 1'b0;
        while (expected_dsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("averaging_channel_mixer_test: PASS");
        else
            $display("averaging_channel_mixer_test: FAIL");
        $finish;
    end

endmodule
